// ===== src/tccomp_pkg.sv =====
// Shared types, constants and the angle table for the tilt-checked compass.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package tccomp_pkg;

    localparam int TABLE_LEN           = 24;
    localparam int ANGLE_ITERATIONS_DEF = 16;
    localparam int IDX_W               = 5;      // indexes the 24-entry table
    localparam int SMP_W               = 16;     // raw sample width
    localparam int HV_W                = 17;     // offset-corrected mag width
    localparam int VEC_W               = 28;     // rotator x/y width, covers gain
    localparam int ANG_W               = 25;     // angle accumulator, 1/256 centideg
    localparam int TAB_W               = 21;
    localparam int HEAD_W              = 16;
    localparam int ACC_W               = 20;     // scaled accel width
    localparam int SCALE_W             = 24;
    localparam int PROD_W              = 40;
    localparam int CFG_W               = 24;
    localparam int CFG_IDX_W           = 2;

    localparam int HALF_TURN           = 18000;
    localparam int FULL_TURN           = 36000;
    localparam int ACCEL_SCALE_RST     = 64269;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_X_OFFSET  = 2'd0,
        CFG_Y_OFFSET  = 2'd1,
        CFG_ACC_SCALE = 2'd2,
        CFG_LEVEL_THR = 2'd3
    } t_cfg_idx;

    typedef enum logic {
        FUNC_COMPASS = 1'b0,
        FUNC_CAL     = 1'b1
    } t_func;

    // handshake between sequencer and scaling unit
    typedef struct packed {
        logic       valid;
        logic [1:0] axis;
    } t_scale_tag;

    // atan(2^-i) in 1/256 centidegree, rounded
    function automatic logic [TAB_W-1:0] atan_step(input logic [IDX_W-1:0] i);
        logic [TAB_W-1:0] t;
        begin
            unique case (i)
                5'd0:  t = 21'd1152000;
                5'd1:  t = 21'd680065;
                5'd2:  t = 21'd359328;
                5'd3:  t = 21'd182400;
                5'd4:  t = 21'd91554;
                5'd5:  t = 21'd45822;
                5'd6:  t = 21'd22916;
                5'd7:  t = 21'd11459;
                5'd8:  t = 21'd5730;
                5'd9:  t = 21'd2865;
                5'd10: t = 21'd1432;
                5'd11: t = 21'd716;
                5'd12: t = 21'd358;
                5'd13: t = 21'd179;
                5'd14: t = 21'd90;
                5'd15: t = 21'd45;
                5'd16: t = 21'd22;
                5'd17: t = 21'd11;
                5'd18: t = 21'd6;
                5'd19: t = 21'd3;
                5'd20: t = 21'd1;
                5'd21: t = 21'd1;
                default: t = 21'd0;
            endcase
            return t;
        end
    endfunction

endpackage

// ===== src/tccomp_cordic.sv =====
// Iterative vectoring rotator: one shift/add step per cycle, gives heading.
// Depends on tccomp_pkg.
`timescale 1ns / 1ps
module tccomp_cordic
    import tccomp_pkg::*;
#(
    parameter int ANGLE_ITERATIONS = ANGLE_ITERATIONS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic signed [HV_W-1:0]   i_hx,
    input  logic signed [HV_W-1:0]   i_hy,
    output logic                     o_done,
    output logic        [HEAD_W-1:0] o_heading
);

    localparam int ITERS = (ANGLE_ITERATIONS > TABLE_LEN) ? TABLE_LEN : ANGLE_ITERATIONS;
    localparam logic [IDX_W-1:0] LAST = IDX_W'(ITERS - 1);

    typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_FIN} t_state;

    t_state                   r_state;
    logic [IDX_W-1:0]         r_cnt;
    logic signed [VEC_W-1:0]  r_x, r_y;
    logic signed [ANG_W-1:0]  r_z;

    logic signed [VEC_W-1:0]  n_x0, n_y0, n_dx, n_dy;
    logic signed [ANG_W-1:0]  n_z0, n_t;
    logic signed [ANG_W-1:0]  n_zr;
    logic signed [HV_W-1:0]   n_c, n_fold;

    always_comb begin
        n_x0 = VEC_W'($signed({i_hx, 8'd0}));
        n_y0 = VEC_W'($signed({i_hy, 8'd0}));
        n_z0 = '0;
        if (i_hx < 0) begin
            n_x0 = -n_x0;
            n_y0 = -n_y0;
            n_z0 = (i_hy >= 0) ? ANG_W'(HALF_TURN * 256) : -ANG_W'(HALF_TURN * 256);
        end
        n_dx = r_y >>> r_cnt;
        n_dy = r_x >>> r_cnt;
        n_t  = ANG_W'(atan_step(r_cnt));
        // round to centidegrees, fold into one turn
        n_zr = r_z + ANG_W'(128);
        n_c  = HV_W'(n_zr >>> 8);
        n_fold = n_c;
        if (n_c < 0) begin
            n_fold = n_c + HV_W'(FULL_TURN);
        end else if (n_c >= HV_W'(FULL_TURN)) begin
            n_fold = n_c - HV_W'(FULL_TURN);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            o_done  <= 1'b0;
        end else begin
            o_done <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (i_start) begin
                        r_x     <= n_x0;
                        r_y     <= n_y0;
                        r_z     <= n_z0;
                        r_cnt   <= '0;
                        r_state <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    if (r_y > 0) begin
                        r_x <= r_x + n_dx;
                        r_y <= r_y - n_dy;
                        r_z <= r_z + n_t;
                    end else if (r_y < 0) begin
                        r_x <= r_x - n_dx;
                        r_y <= r_y + n_dy;
                        r_z <= r_z - n_t;
                    end
                    r_cnt <= r_cnt + IDX_W'(1);
                    if (r_cnt == LAST) begin
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    o_heading <= HEAD_W'(n_fold);
                    o_done    <= 1'b1;
                    r_state   <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

// ===== src/tccomp_scale.sv =====
// Shared accel scaler: registered multiply, then round and saturate.
// Depends on tccomp_pkg.
`timescale 1ns / 1ps
module tccomp_scale
    import tccomp_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_scale_tag                i_tag,
    input  logic signed [SMP_W-1:0]   i_acc,
    input  logic        [SCALE_W-1:0] i_scale,
    output t_scale_tag                o_tag,
    output logic signed [ACC_W-1:0]   o_val
);

    t_scale_tag               r_tag;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [PROD_W:0]   n_full;
    logic        [PROD_W-1:0] n_mag, n_rnd;
    logic        [SCALE_W-1:0] n_r;
    logic signed [ACC_W-1:0]  n_sat;

    always_comb begin
        n_full = $signed(i_acc) * $signed({1'b0, i_scale});
        n_mag  = (r_prod < 0) ? PROD_W'(-r_prod) : PROD_W'(r_prod);
        n_rnd  = n_mag + PROD_W'(32768);
        n_r    = n_rnd[PROD_W-1:16];
        if (r_prod < 0) begin
            n_sat = (n_r > SCALE_W'(524288)) ? ACC_W'(-524288) : -ACC_W'(n_r);
        end else begin
            n_sat = (n_r > SCALE_W'(524287)) ? ACC_W'(524287) : ACC_W'(n_r);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag <= '0;
            o_tag <= '0;
        end else begin
            r_tag  <= i_tag;
            r_prod <= PROD_W'(n_full);
            o_tag  <= r_tag;
            o_val  <= n_sat;
        end
    end

endmodule

// ===== src/tilt_checked_compass_with_hard_iron_cal_core.sv =====
// Top level of the tilt-checked compass with hard-iron calibration.
// Depends on tccomp_pkg, tccomp_cordic, tccomp_scale.
`timescale 1ns / 1ps
//
//  channel  | direction | handshake                | word
//  ---------+-----------+--------------------------+--------------------------------
//  input    | in        | i_in_valid / o_in_stall  | func, acc_x/y/z, mag_x/y/z
//  output   | out       | o_out_valid / i_out_stall| heading, accel_*_scaled,
//           |           |                          | not_level, mid_x/y/z
//  config   | in        | i_cfg_we (no wait)       | i_cfg_idx, i_cfg_data
//
//  Compass word: the angle rotator runs ANGLE_ITERATIONS shift/add steps (capped at
//  24), one per cycle, then the result loads into the output register; the next
//  word can be taken in the cycle after the output loads.
//  Calibration word: min/max update, midpoint, then output load.
//  Accel axes share one multiplier, issued on consecutive cycles during rotation.
//  One word in flight; o_in_stall is high from accept until the result sits in
//  the output register, which holds while i_out_stall is high.
//  Reset is synchronous, active low; calibration restart is armed on reset.
module tilt_checked_compass_with_hard_iron_cal_core
    import tccomp_pkg::*;
#(
    parameter int ANGLE_ITERATIONS = ANGLE_ITERATIONS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // config
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [CFG_W-1:0]          i_cfg_data,
    // input word
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic                      i_func,
    input  logic signed [SMP_W-1:0]   i_acc_x,
    input  logic signed [SMP_W-1:0]   i_acc_y,
    input  logic signed [SMP_W-1:0]   i_acc_z,
    input  logic signed [SMP_W-1:0]   i_mag_x,
    input  logic signed [SMP_W-1:0]   i_mag_y,
    input  logic signed [SMP_W-1:0]   i_mag_z,
    // output word
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic        [HEAD_W-1:0]  o_heading_centideg,
    output logic signed [ACC_W-1:0]   o_accel_x_scaled,
    output logic signed [ACC_W-1:0]   o_accel_y_scaled,
    output logic signed [ACC_W-1:0]   o_accel_z_scaled,
    output logic                      o_not_level,
    output logic signed [SMP_W-1:0]   o_mid_x,
    output logic signed [SMP_W-1:0]   o_mid_y,
    output logic signed [SMP_W-1:0]   o_mid_z
);

    typedef enum logic [2:0] {
        ST_IDLE, ST_COMPASS, ST_CAL_UPD, ST_CAL_MID, ST_OUT
    } t_state;

    // config registers
    logic signed [SMP_W-1:0]   r_x_off, r_y_off;
    logic        [SCALE_W-1:0] r_acc_scale;
    logic signed [ACC_W-1:0]   r_level_thr;

    // sequencer and working state
    t_state                    r_state;
    t_func                     r_mode;
    logic                      r_restart;
    logic [1:0]                r_iss;
    logic signed [SMP_W-1:0]   r_smp [3];   // accel in compass mode, mag in cal mode
    logic signed [SMP_W-1:0]   r_min [3];
    logic signed [SMP_W-1:0]   r_max [3];
    logic signed [SMP_W-1:0]   r_mid [3];
    logic signed [ACC_W-1:0]   r_accs [3];
    logic                      r_not_level;

    logic                      n_accept, n_start, n_done;
    logic signed [HV_W-1:0]    n_hx, n_hy;
    logic [HEAD_W-1:0]         n_heading;
    t_scale_tag                n_iss_tag, n_res_tag;
    logic signed [SMP_W-1:0]   n_iss_acc;
    logic signed [ACC_W-1:0]   n_res_val;
    logic signed [SMP_W-1:0]   n_lo [3];
    logic signed [SMP_W-1:0]   n_hi [3];
    logic signed [SMP_W-1:0]   n_mid [3];
    logic signed [SMP_W:0]     n_sum [3];
    logic signed [SMP_W:0]     n_half [3];
    logic                      n_load;

    assign o_in_stall = (r_state != ST_IDLE);
    assign n_accept   = i_in_valid && !o_in_stall;
    assign n_start    = n_accept && (t_func'(i_func) == FUNC_COMPASS);
    assign n_hx       = HV_W'(i_mag_x) + HV_W'(r_x_off);
    assign n_hy       = HV_W'(i_mag_y) + HV_W'(r_y_off);
    assign n_load     = (r_state == ST_OUT) && (!o_out_valid || !i_out_stall);

    tccomp_cordic #(
        .ANGLE_ITERATIONS (ANGLE_ITERATIONS)
    ) u_cordic (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (n_start),
        .i_hx      (n_hx),
        .i_hy      (n_hy),
        .o_done    (n_done),
        .o_heading (n_heading)
    );

    // one accel axis per cycle into the shared scaler
    always_comb begin
        n_iss_tag.valid = (r_state == ST_COMPASS) && (r_iss != 2'd3);
        n_iss_tag.axis  = r_iss;
        n_iss_acc       = (r_iss == 2'd0) ? r_smp[0] :
                          (r_iss == 2'd1) ? r_smp[1] : r_smp[2];
    end

    tccomp_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (n_iss_tag),
        .i_acc   (n_iss_acc),
        .i_scale (r_acc_scale),
        .o_tag   (n_res_tag),
        .o_val   (n_res_val)
    );

    // calibration: widen min/max (cleared first when a restart is armed),
    // then midpoint rounded half to even
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_lo[k] = r_restart ? '0 : r_min[k];
            n_hi[k] = r_restart ? '0 : r_max[k];
            if (r_smp[k] < n_lo[k]) begin
                n_lo[k] = r_smp[k];
            end
            if (r_smp[k] > n_hi[k]) begin
                n_hi[k] = r_smp[k];
            end
            n_sum[k]  = (SMP_W+1)'(r_min[k]) + (SMP_W+1)'(r_max[k]);
            n_half[k] = n_sum[k] >>> 1;
            if (n_sum[k][0] && n_half[k][0]) begin
                n_half[k] = n_half[k] + (SMP_W+1)'(1);
            end
            n_mid[k] = SMP_W'(n_half[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_off     <= '0;
            r_y_off     <= '0;
            r_acc_scale <= SCALE_W'(ACCEL_SCALE_RST);
            r_level_thr <= '0;
            r_state     <= ST_IDLE;
            r_mode      <= FUNC_COMPASS;
            r_restart   <= 1'b1;
            r_iss       <= '0;
            o_out_valid <= 1'b0;
            for (int k = 0; k < 3; k++) begin
                r_min[k] <= '0;
                r_max[k] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_X_OFFSET:  r_x_off     <= i_cfg_data[SMP_W-1:0];
                    CFG_Y_OFFSET:  r_y_off     <= i_cfg_data[SMP_W-1:0];
                    CFG_ACC_SCALE: r_acc_scale <= i_cfg_data[SCALE_W-1:0];
                    CFG_LEVEL_THR: r_level_thr <= i_cfg_data[ACC_W-1:0];
                    default: ;
                endcase
            end

            // scaler results land by axis tag
            if (n_res_tag.valid) begin
                unique case (n_res_tag.axis)
                    2'd0: r_accs[0] <= n_res_val;
                    2'd1: r_accs[1] <= n_res_val;
                    default: begin
                        r_accs[2]   <= n_res_val;
                        r_not_level <= (n_res_val < r_level_thr);
                    end
                endcase
            end

            if (n_load) begin
                o_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                o_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (n_accept) begin
                        r_mode <= t_func'(i_func);
                        r_iss  <= '0;
                        if (t_func'(i_func) == FUNC_COMPASS) begin
                            r_smp[0] <= i_acc_x;
                            r_smp[1] <= i_acc_y;
                            r_smp[2] <= i_acc_z;
                            r_state  <= ST_COMPASS;
                        end else begin
                            r_smp[0] <= i_mag_x;
                            r_smp[1] <= i_mag_y;
                            r_smp[2] <= i_mag_z;
                            r_state  <= ST_CAL_UPD;
                        end
                    end
                end
                ST_COMPASS: begin
                    if (r_iss != 2'd3) begin
                        r_iss <= r_iss + 2'd1;
                    end
                    // with the default ANGLE_ITERATIONS the rotator outlasts the three scaler passes
                    if (n_done) begin
                        r_restart <= 1'b1;
                        r_state   <= ST_OUT;
                    end
                end
                ST_CAL_UPD: begin
                    for (int k = 0; k < 3; k++) begin
                        r_min[k] <= n_lo[k];
                        r_max[k] <= n_hi[k];
                    end
                    r_restart <= 1'b0;
                    r_state   <= ST_CAL_MID;
                end
                ST_CAL_MID: begin
                    for (int k = 0; k < 3; k++) begin
                        r_mid[k] <= n_mid[k];
                    end
                    r_state <= ST_OUT;
                end
                ST_OUT: begin
                    if (n_load) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // output word register, held while stalled
    always_ff @(posedge i_clk) begin
        if (n_load) begin
            if (r_mode == FUNC_COMPASS) begin
                o_heading_centideg <= n_heading;
                o_accel_x_scaled   <= r_accs[0];
                o_accel_y_scaled   <= r_accs[1];
                o_accel_z_scaled   <= r_accs[2];
                o_not_level        <= r_not_level;
                o_mid_x            <= '0;
                o_mid_y            <= '0;
                o_mid_z            <= '0;
            end else begin
                o_heading_centideg <= '0;
                o_accel_x_scaled   <= '0;
                o_accel_y_scaled   <= '0;
                o_accel_z_scaled   <= '0;
                o_not_level        <= 1'b0;
                o_mid_x            <= r_mid[0];
                o_mid_y            <= r_mid[1];
                o_mid_z            <= r_mid[2];
            end
        end
    end

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for tilt_checked_compass_with_hard_iron_cal_core.
// Needs tccomp_pkg and the core RTL. A built-in predictor checks every result word,
// covering compass heading, accel scaling, level flag and calibration midpoints.
`timescale 1ns / 1ps
module tb;
    import tccomp_pkg::*;

    localparam int ANGLE_STEPS  = ANGLE_ITERATIONS_DEF;
    localparam int RAND_PER_SEG = 115;      // six segments, about 700 random words
    localparam int HOLD_CYCLES  = 300;      // long receiver hold-off, once
    localparam int CYCLE_LIMIT  = 200000;   // watchdog, well above the slowest legal run
    localparam int DRAIN_CYCLES = 40;       // longer than one compass word

    // one input word
    typedef struct packed {
        t_func                   func;
        logic signed [SMP_W-1:0] ax, ay, az;
        logic signed [SMP_W-1:0] mx, my, mz;
    } sample_t;

    // one result word
    typedef struct packed {
        logic        [HEAD_W-1:0] heading;
        logic signed [ACC_W-1:0]  acc_x, acc_y, acc_z;
        logic                     not_level;
        logic signed [SMP_W-1:0]  mid_x, mid_y, mid_z;
    } reading_t;

    // directed row: word plus optional hand-typed heading or midpoints
    typedef struct packed {
        sample_t                 w;
        logic                    pin;
        logic        [HEAD_W-1:0] head;
        logic signed [SMP_W-1:0]  pmx, pmy, pmz;
    } row_t;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_cfg_we;
    logic [CFG_IDX_W-1:0]    i_cfg_idx;
    logic [CFG_W-1:0]        i_cfg_data;
    logic                    i_in_valid;
    logic                    o_in_stall;
    logic                    i_func;
    logic signed [SMP_W-1:0] i_acc_x, i_acc_y, i_acc_z;
    logic signed [SMP_W-1:0] i_mag_x, i_mag_y, i_mag_z;
    logic                    o_out_valid;
    logic                    i_out_stall = 1'b0;
    logic        [HEAD_W-1:0] o_heading_centideg;
    logic signed [ACC_W-1:0]  o_accel_x_scaled, o_accel_y_scaled, o_accel_z_scaled;
    logic                    o_not_level;
    logic signed [SMP_W-1:0] o_mid_x, o_mid_y, o_mid_z;

    // predictor copy of the registers and the calibration state
    logic signed [15:0] x_off, y_off;
    logic        [23:0] acc_gain;
    logic signed [19:0] tilt_limit;
    bit                 restart_armed;
    logic signed [15:0] lo_mag [3];
    logic signed [15:0] hi_mag [3];

    // atan(2^-i), 1/256 centidegree
    longint arc_step [0:23] = '{1152000, 680065, 359328, 182400, 91554, 45822,
                                22916, 11459, 5730, 2865, 1432, 716, 358, 179,
                                90, 45, 22, 11, 6, 3, 1, 1, 0, 0};

    reading_t pending_readings [$];
    int       faults = 0;
    int       cycles = 0;
    int       snd_pct, rcv_pct;
    bit       hold_go = 0;
    bit       hold_done = 0;
    int       hold_cnt = 0;
    reading_t seen, want;

    tilt_checked_compass_with_hard_iron_cal_core #(
        .ANGLE_ITERATIONS (ANGLE_STEPS)
    ) dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_func             (i_func),
        .i_acc_x            (i_acc_x),
        .i_acc_y            (i_acc_y),
        .i_acc_z            (i_acc_z),
        .i_mag_x            (i_mag_x),
        .i_mag_y            (i_mag_y),
        .i_mag_z            (i_mag_z),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_heading_centideg (o_heading_centideg),
        .o_accel_x_scaled   (o_accel_x_scaled),
        .o_accel_y_scaled   (o_accel_y_scaled),
        .o_accel_z_scaled   (o_accel_z_scaled),
        .o_not_level        (o_not_level),
        .o_mid_x            (o_mid_x),
        .o_mid_y            (o_mid_y),
        .o_mid_z            (o_mid_z)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------- predictor

    // vectoring rotator: angle of (hx, hy), rounded to centidegrees, 0..35999
    function automatic logic [15:0] heading_cd(longint hx, longint hy);
        longint x, y, z, dx, dy, c;
        int     n;
        if (hx == 0 && hy == 0)
            return '0;
        x = hx * 256;
        y = hy * 256;
        z = 0;
        n = (ANGLE_STEPS > TABLE_LEN) ? TABLE_LEN : ANGLE_STEPS;
        if (hx < 0) begin
            // left half plane: flip the vector, start from +/- half turn
            z = (hy >= 0) ? HALF_TURN * 256 : -HALF_TURN * 256;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < n; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0) begin
                x = x + dx;
                y = y - dy;
                z = z + arc_step[i];
            end else if (y < 0) begin
                x = x - dx;
                y = y + dy;
                z = z - arc_step[i];
            end
        end
        c = (z + 128) >>> 8;
        if (c < 0)
            c = c + FULL_TURN;
        if (c >= FULL_TURN)
            c = c - FULL_TURN;
        return c[15:0];
    endfunction

    // raw accel times gain/65536, nearest with ties away from zero, saturated
    function automatic logic signed [19:0] scale_axis(logic signed [15:0] a);
        longint p, m, r;
        p = longint'(a) * longint'(acc_gain);
        m = (p < 0) ? -p : p;
        r = (m + 32768) >>> 16;
        if (p < 0)
            r = -r;
        if (r > 524287)
            r = 524287;
        if (r < -524288)
            r = -524288;
        return r[19:0];
    endfunction

    function automatic reading_t predict_reading(sample_t w);
        reading_t           r;
        logic signed [15:0] m   [3];
        logic signed [15:0] mid [3];
        longint             s, f;
        r = '0;
        m[0] = w.mx;
        m[1] = w.my;
        m[2] = w.mz;
        if (w.func == FUNC_COMPASS) begin
            r.heading   = heading_cd(longint'(w.mx) + longint'(x_off),
                                     longint'(w.my) + longint'(y_off));
            r.acc_x     = scale_axis(w.ax);
            r.acc_y     = scale_axis(w.ay);
            r.acc_z     = scale_axis(w.az);
            r.not_level = (r.acc_z < tilt_limit);
            restart_armed = 1;
        end else begin
            if (restart_armed) begin
                for (int k = 0; k < 3; k++) begin
                    lo_mag[k] = '0;
                    hi_mag[k] = '0;
                end
            end
            restart_armed = 0;
            for (int k = 0; k < 3; k++) begin
                if (m[k] < lo_mag[k])
                    lo_mag[k] = m[k];
                if (m[k] > hi_mag[k])
                    hi_mag[k] = m[k];
                // midpoint, halves rounded to even
                s = longint'(lo_mag[k]) + longint'(hi_mag[k]);
                f = s >>> 1;
                if (s[0] && f[0])
                    f = f + 1;
                mid[k] = f[15:0];
            end
            r.mid_x = mid[0];
            r.mid_y = mid[1];
            r.mid_z = mid[2];
        end
        return r;
    endfunction

    function automatic logic [19:0] field_of(reading_t r, int k);
        case (k)
            0: return 20'(r.heading);
            1: return r.acc_x;
            2: return r.acc_y;
            3: return r.acc_z;
            4: return 20'(r.not_level);
            5: return 20'(r.mid_x);
            6: return 20'(r.mid_y);
            default: return 20'(r.mid_z);
        endcase
    endfunction

    function automatic string field_name(int k);
        case (k)
            0: return "heading_centideg";
            1: return "accel_x_scaled";
            2: return "accel_y_scaled";
            3: return "accel_z_scaled";
            4: return "not_level";
            5: return "mid_x";
            6: return "mid_y";
            default: return "mid_z";
        endcase
    endfunction

    // ---------------------------------------------------------------- stimulus

    function automatic row_t plan_row(t_func f, int ax, int ay, int az, int mx, int my,
                                      int mz, bit pin, int h, int px, int py, int pz);
        row_t r;
        r.w.func = f;
        r.w.ax   = 16'(ax);
        r.w.ay   = 16'(ay);
        r.w.az   = 16'(az);
        r.w.mx   = 16'(mx);
        r.w.my   = 16'(my);
        r.w.mz   = 16'(mz);
        r.pin    = pin;
        r.head   = 16'(h);
        r.pmx    = 16'(px);
        r.pmy    = 16'(py);
        r.pmz    = 16'(pz);
        return r;
    endfunction

    function automatic logic signed [15:0] rail_value();
        case ($urandom_range(0, 4))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return 16'sh0000;
            3: return 16'shFFFF;
            default: return 16'sh0001;
        endcase
    endfunction

    function automatic sample_t random_sample(t_func f);
        sample_t w;
        w.func = f;
        if ($urandom_range(0, 1)) begin
            w.ax = 16'($urandom);
            w.ay = 16'($urandom);
            w.az = 16'($urandom);
        end else begin
            // near one g on a few thousand LSB, keeps the level flag busy
            w.ax = 16'(int'($urandom_range(0, 4000)) - 2000);
            w.ay = 16'(int'($urandom_range(0, 4000)) - 2000);
            w.az = 16'(int'($urandom_range(0, 4000)) - 2000);
        end
        w.mx = 16'($urandom);
        w.my = 16'($urandom);
        w.mz = 16'($urandom);
        case ($urandom_range(0, 9))
            5, 6: begin
                w.mx = 16'(int'($urandom_range(0, 600)) - 300);
                w.my = 16'(int'($urandom_range(0, 600)) - 300);
                w.mz = 16'(int'($urandom_range(0, 600)) - 300);
            end
            7: w.my = -y_off;                   // corrected vector on the X axis
            8: begin
                w.mx = -x_off;                  // corrected vector near zero
                w.my = -y_off;
            end
            9: begin
                w.mx = rail_value();
                w.my = rail_value();
                w.mz = rail_value();
            end
            default: ;
        endcase
        return w;
    endfunction

    // Present one word from a falling edge, wait for accept, log its expectation.
    // Leaves valid high on return; the next call or the caller drives or lowers it.
    task automatic offer(row_t rw);
        reading_t exp_word;
        while (snd_pct > 0 && $urandom_range(1, 100) <= snd_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_func     = rw.w.func;
        i_acc_x    = rw.w.ax;
        i_acc_y    = rw.w.ay;
        i_acc_z    = rw.w.az;
        i_mag_x    = rw.w.mx;
        i_mag_y    = rw.w.my;
        i_mag_z    = rw.w.mz;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        exp_word = predict_reading(rw.w);
        if (rw.pin) begin
            if (rw.w.func == FUNC_COMPASS) begin
                exp_word.heading = rw.head;
            end else begin
                exp_word.mid_x = rw.pmx;
                exp_word.mid_y = rw.pmy;
                exp_word.mid_z = rw.pmz;
            end
        end
        pending_readings.push_back(exp_word);
        @(negedge i_clk);
    endtask

    // every word yields a result, so an empty queue means the core is idle
    task automatic wait_idle();
        i_in_valid = 1'b0;
        while (pending_readings.size() > 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic set_reg(t_cfg_idx idx, logic [CFG_W-1:0] v);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = v;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
        // bits above each register's width are dropped
        case (idx)
            CFG_X_OFFSET:  x_off      = v[15:0];
            CFG_Y_OFFSET:  y_off      = v[15:0];
            CFG_ACC_SCALE: acc_gain   = v[23:0];
            CFG_LEVEL_THR: tilt_limit = v[19:0];
            default: ;
        endcase
    endtask

    task automatic random_segment(int n);
        int    left, run;
        t_func f;
        row_t  rw;
        left = n;
        rw   = '0;
        // runs of one function: compass or calibration bursts of one to eight words, at random
        while (left > 0) begin
            f   = $urandom_range(0, 1) ? FUNC_CAL : FUNC_COMPASS;
            run = $urandom_range(1, 8);
            for (int k = 0; k < run && left > 0; k++) begin
                rw.w = random_sample(f);
                offer(rw);
                left--;
            end
        end
    endtask

    // ---------------------------------------------------------------- receiver

    // random stall, plus one long hold-off counted here so the core backs up
    always @(negedge i_clk) begin
        if (hold_go && !hold_done) begin
            i_out_stall = 1'b1;
            hold_cnt++;
            if (hold_cnt >= HOLD_CYCLES)
                hold_done = 1;
        end else begin
            i_out_stall = (rcv_pct > 0) && ($urandom_range(1, 100) <= rcv_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            seen.heading   = o_heading_centideg;
            seen.acc_x     = o_accel_x_scaled;
            seen.acc_y     = o_accel_y_scaled;
            seen.acc_z     = o_accel_z_scaled;
            seen.not_level = o_not_level;
            seen.mid_x     = o_mid_x;
            seen.mid_y     = o_mid_y;
            seen.mid_z     = o_mid_z;
            if (pending_readings.size() == 0) begin
                faults++;
                $display("%0t ns: result word, expected none, got heading %0d mid_x %0d",
                         $time, seen.heading, seen.mid_x);
            end else begin
                want = pending_readings.pop_front();
                for (int k = 0; k < 8; k++) begin
                    if (field_of(want, k) !== field_of(seen, k)) begin
                        faults++;
                        $display("%0t ns: %s expected %h got %h", $time, field_name(k),
                                 field_of(want, k), field_of(seen, k));
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tilt_checked_compass_with_hard_iron_cal_core test failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------- main

    initial begin
        row_t plan [$];

        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = CFG_X_OFFSET;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_func     = FUNC_COMPASS;
        i_acc_x    = '0;
        i_acc_y    = '0;
        i_acc_z    = '0;
        i_mag_x    = '0;
        i_mag_y    = '0;
        i_mag_z    = '0;
        snd_pct    = 13;
        rcv_pct    = 54;

        // reset values of the registers and calibration state
        x_off         = '0;
        y_off         = '0;
        acc_gain      = 24'(ACCEL_SCALE_RST);
        tilt_limit    = '0;
        restart_armed = 1;
        for (int k = 0; k < 3; k++) begin
            lo_mag[k] = '0;
            hi_mag[k] = '0;
        end

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed words on reset registers.
        //                   func          ax      ay      az      mx      my      mz
        //                                 pin head  mid x/y/z
        // calibration straight out of reset
        plan.push_back(plan_row(FUNC_CAL, 9, 9, 9, 0, 0, 0, 1, 0, 0, 0, 0));
        // zero vector, and the positive and negative X axis
        plan.push_back(plan_row(FUNC_COMPASS, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0));
        plan.push_back(plan_row(FUNC_COMPASS, 100, -100, 1000, 100, 0, 0, 1, 0, 0, 0, 0));
        plan.push_back(plan_row(FUNC_COMPASS, 0, 0, -1, -100, 0, 0, 1, 18000, 0, 0, 0));
        plan.push_back(plan_row(FUNC_COMPASS, 5, 6, 7, 0, 100, 0, 0, 0, 0, 0, 0));
        plan.push_back(plan_row(FUNC_COMPASS, -5, -6, -7, 0, -100, 0, 0, 0, 0, 0, 0));
        // accel and mag extremes
        plan.push_back(plan_row(FUNC_COMPASS, 32767, -32768, 32767,
                                32767, 32767, 32767, 0, 0, 0, 0, 0));
        plan.push_back(plan_row(FUNC_COMPASS, -32768, 32767, -32768,
                                -32768, -32768, -32768, 0, 0, 0, 0, 0));
        // just below the X axis from both sides, wrap near full and half turn
        plan.push_back(plan_row(FUNC_COMPASS, 1, 1, 1, 32767, -1, 0, 0, 0, 0, 0, 0));
        plan.push_back(plan_row(FUNC_COMPASS, 1, 1, 1, -32768, -1, 0, 0, 0, 0, 0, 0));
        plan.push_back(plan_row(FUNC_COMPASS, 1, 1, 1, -1, 32767, 0, 0, 0, 0, 0, 0));
        // calibration after compass: ranges restart from zero; ties go to even
        plan.push_back(plan_row(FUNC_CAL, 500, 500, 500, 100, -50, 7, 1, 0, 50, -25, 4));
        plan.push_back(plan_row(FUNC_CAL, -1, -1, -1, -101, 50, -7, 1, 0, 0, 0, 0));
        plan.push_back(plan_row(FUNC_CAL, 32767, 32767, 32767,
                                32767, -32768, 32767, 0, 0, 0, 0, 0));
        plan.push_back(plan_row(FUNC_CAL, -32768, -32768, -32768,
                                -32768, 32767, -32768, 1, 0, 0, 0, 0));
        plan.push_back(plan_row(FUNC_CAL, 0, 0, 0, 1, 1, 1, 1, 0, 0, 0, 0));
        // compass re-arms the restart
        plan.push_back(plan_row(FUNC_COMPASS, 200, -300, 4000, 3, 4, 0, 0, 0, 0, 0, 0));
        plan.push_back(plan_row(FUNC_CAL, 0, 0, 0, 3, -3, 0, 1, 0, 2, -2, 0));
        plan.push_back(plan_row(FUNC_CAL, 0, 0, 0, 5, 0, -5, 1, 0, 2, -2, -2));
        plan.push_back(plan_row(FUNC_COMPASS, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0));

        foreach (plan[i])
            offer(plan[i]);

        // Random segments, each on its own register setting:
        // two per idle pattern, extremes first, junk in the upper data bits.
        for (int seg = 0; seg < 6; seg++) begin
            wait_idle();
            case (seg / 2)
                0: begin snd_pct = 13; rcv_pct = 54; end
                1: begin snd_pct = 54; rcv_pct = 13; end
                default: begin snd_pct = 0; rcv_pct = 0; end
            endcase
            if (seg == 0) begin
                set_reg(CFG_X_OFFSET,  24'hA57FFF);
                set_reg(CFG_Y_OFFSET,  24'h5A8000);
                set_reg(CFG_ACC_SCALE, 24'hFFFFFF);
                set_reg(CFG_LEVEL_THR, 24'hF80000);
            end else if (seg == 1) begin
                set_reg(CFG_X_OFFSET,  24'h008000);
                set_reg(CFG_Y_OFFSET,  24'hFF7FFF);
                set_reg(CFG_ACC_SCALE, 24'h000000);
                set_reg(CFG_LEVEL_THR, 24'h07FFFF);
            end else begin
                set_reg(CFG_X_OFFSET, 24'($urandom));
                set_reg(CFG_Y_OFFSET, 24'($urandom));
                set_reg(CFG_ACC_SCALE, ($urandom_range(0, 3) == 0) ?
                        24'($urandom) : 24'($urandom_range(20000, 140000)));
                set_reg(CFG_LEVEL_THR, ($urandom_range(0, 2) == 0) ? 24'($urandom) :
                        {4'($urandom), 20'(int'($urandom_range(0, 60000)) - 30000)});
            end
            if (seg == 4)
                hold_go = 1;
            random_segment(RAND_PER_SEG);
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (faults == 0 && pending_readings.size() == 0)
            $display("tilt_checked_compass_with_hard_iron_cal_core test passed");
        else
            $display("tilt_checked_compass_with_hard_iron_cal_core test failed");
        $finish;
    end

endmodule
